[hdl/solarize_pixel_curve_assert.svh]
// solarize_pixel_curve_assert.svh: assertion macros for the solarize curve block
// needs a clock i_clk and an active-low reset i_rst_n in the scope of use
`ifndef SOLARIZE_PIXEL_CURVE_ASSERT_SVH
`define SOLARIZE_PIXEL_CURVE_ASSERT_SVH

// condition holds at every clock edge outside reset
`define SPC_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/spc_pkg.sv]
// spc_pkg: types and constants shared by the solarize curve pipeline
// no dependencies
`timescale 1ns / 1ps

package spc_pkg;

    localparam int unsigned REM_W  = 20;
    localparam int unsigned DIV_W  = 9;
    localparam int unsigned QUOT_W = 9;
    localparam int unsigned LEN_W  = 10;
    localparam int unsigned CFG_W  = 9;

    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_START     = 2'd1;
    localparam logic [1:0] CFG_END       = 2'd2;

    localparam logic [7:0] BYTE_MAX = 8'hff;

    // how the final byte of a lane is formed
    typedef enum logic [1:0] {
        RES_DIV  = 2'd0,
        RES_ZERO = 2'd1,
        RES_ONE  = 2'd2,
        RES_MAX  = 2'd3
    } t_res;

    // data of one channel lane as it moves down the cell chain
    typedef struct packed {
        logic              neg;
        t_res              kind;
        logic [REM_W-1:0]  rem;
        logic [DIV_W-1:0]  dvs;
        logic [QUOT_W-1:0] quot;
    } t_lane;

    // curve lengths from the configuration, zero forced to one
    typedef struct packed {
        logic signed [LEN_W-1:0] up;
        logic signed [LEN_W-1:0] down;
    } t_curve;

    // final byte of a lane leaving the division chain
    function automatic logic [7:0] lane_byte(input t_lane lane);
        logic [7:0] res;
        res = 8'd0;
        unique case (lane.kind)
            RES_DIV:  res = lane.quot[8] ? BYTE_MAX : lane.quot[7:0];
            RES_ZERO: res = 8'd0;
            RES_ONE:  res = 8'd1;
            RES_MAX:  res = BYTE_MAX;
            default:  res = 8'd0;
        endcase
        return res;
    endfunction

endpackage

[hdl/spc_div_cell.sv]
// spc_div_cell: one restoring division step for one channel lane
// depends on spc_pkg
`timescale 1ns / 1ps

module spc_div_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  spc_pkg::t_lane i_lane,
    output spc_pkg::t_lane o_lane
);

    spc_pkg::t_lane r_lane;
    spc_pkg::t_lane n_lane;
    logic [spc_pkg::REM_W-1:0] w_sub;

    // subtract the shifted divisor when it fits and set this quotient bit
    always_comb begin
        w_sub  = spc_pkg::REM_W'(i_lane.dvs) << SHIFT;
        n_lane = i_lane;
        if (i_lane.rem >= w_sub) begin
            n_lane.rem         = i_lane.rem - w_sub;
            n_lane.quot[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

[hdl/spc_branch.sv]
// spc_branch: picks the rising or falling side of the curve for one lane
// and sets up the scaled numerator for the second division chain
// depends on spc_pkg
`timescale 1ns / 1ps

module spc_branch (
    input  logic           i_clk,
    input  logic           i_en,
    input  spc_pkg::t_curve i_curve,
    input  spc_pkg::t_lane  i_lane,
    output spc_pkg::t_lane  o_lane
);

    spc_pkg::t_lane r_lane;
    spc_pkg::t_lane n_lane;

    logic signed [10:0] w_p;
    logic signed [10:0] w_up;
    logic        [10:0] w_mag;
    logic               w_lt;
    logic signed [11:0] w_num;
    logic signed [9:0]  w_den;
    logic        [10:0] w_anum;
    logic        [19:0] w_scaled;
    logic        [9:0]  w_nden;

    always_comb begin
        // signed remainder from its magnitude and the dividend sign
        w_mag = {1'b0, i_lane.rem[9:0]};
        w_p   = i_lane.neg ? -$signed(w_mag) : $signed(w_mag);
        w_up  = {i_curve.up[9], i_curve.up};
        w_lt  = w_p < w_up;

        // numerator and length of the selected side
        if (w_lt) begin
            w_num = {w_p[10], w_p};
            w_den = i_curve.up;
        end else begin
            w_num = {{2{i_curve.down[9]}}, i_curve.down} - {w_p[10], w_p}
                  + {{2{i_curve.up[9]}}, i_curve.up};
            w_den = i_curve.down;
        end

        w_anum   = w_num[11] ? 11'(-w_num) : w_num[10:0];
        w_scaled = {1'b0, w_anum, 8'd0} - 20'(w_anum);
        w_nden   = 10'(-w_den);

        // 32-bit unsigned quotient reduced to its few outcomes
        n_lane      = '0;
        n_lane.dvs  = w_den[8:0];
        n_lane.kind = spc_pkg::RES_DIV;
        n_lane.rem  = w_scaled;
        priority if (!w_num[11] && !w_den[9]) begin
            n_lane.kind = spc_pkg::RES_DIV;
        end else if (!w_num[11]) begin
            n_lane.kind = spc_pkg::RES_ZERO;
        end else if (!w_den[9]) begin
            n_lane.kind = (w_den == 10'sd1) ? spc_pkg::RES_ZERO : spc_pkg::RES_MAX;
        end else begin
            n_lane.kind = (w_scaled <= 20'(w_nden)) ? spc_pkg::RES_ONE : spc_pkg::RES_ZERO;
        end
        if (n_lane.kind != spc_pkg::RES_DIV) begin
            n_lane.rem = '0;
            n_lane.dvs = 9'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

[hdl/solarize_pixel_curve.sv]
// solarize_pixel_curve: top level of the solarize curve pixel pipeline
// depends on spc_pkg, spc_div_cell, spc_branch, solarize_pixel_curve_assert.svh
//
// Usage:
//   slave stream takes one pixel per transaction: tdata holds chan_hi, chan_mid,
//   chan_lo from the lowest byte up, tlast marks the last pixel of a frame.
//   master stream gives one curved pixel per transaction in the same layout,
//   tlast copied from the input.
//   config channel writes threshold (index 0), start (1) and end (2); it is
//   always ready. The user must write it only while no pixel is in flight;
//   the block itself does not enforce this. One pixel enters every cycle unless stalled.
//   the pipeline is two chains of nine division cells per channel
//   (remainder by the period, then quotient by the side length), one
//   branch stage and the output register.
//   a stalled receiver holds the output register and freezes the whole
//   chain, so input tready drops until the output transaction completes.
//   reset empties the pipeline and loads threshold 127, start 50, end 185.
`timescale 1ns / 1ps
`include "solarize_pixel_curve_assert.svh"

module solarize_pixel_curve (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // chan_hi, chan_mid, chan_lo
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // out_hi, out_mid, out_lo
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    localparam int unsigned NSTEP  = 9;
    localparam int unsigned NSTAGE = 2 * NSTEP + 2;

    logic [8:0] r_threshold;
    logic [8:0] r_start;
    logic [8:0] r_end;

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] r_last;
    logic [23:0]       r_data;

    logic w_en;
    logic w_in_acc;

    logic signed [9:0] w_period;
    logic signed [9:0] w_up;
    logic signed [9:0] w_down;
    logic        [8:0] w_aper;
    spc_pkg::t_curve   w_curve;

    spc_pkg::t_lane w_a [3][NSTEP+1];
    spc_pkg::t_lane w_b [3][NSTEP+1];

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 9'd127;
            r_start     <= 9'd50;
            r_end       <= 9'd185;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == spc_pkg::CFG_THRESHOLD) r_threshold <= i_cfg_data;
            if (i_cfg_index == spc_pkg::CFG_START)     r_start     <= i_cfg_data;
            if (i_cfg_index == spc_pkg::CFG_END)       r_end       <= i_cfg_data;
        end
    end

    // curve lengths, zero forced to one
    always_comb begin
        w_period = $signed({1'b0, r_end}) - $signed({1'b0, r_start});
        w_up     = $signed({1'b0, r_threshold}) - $signed({1'b0, r_start});
        w_down   = $signed({1'b0, r_end}) - $signed({1'b0, r_threshold});
        if (w_period == 10'sd0) w_period = 10'sd1;
        if (w_up == 10'sd0)     w_up     = 10'sd1;
        if (w_down == 10'sd0)   w_down   = 10'sd1;
        w_aper        = w_period[9] ? 9'(-w_period) : w_period[8:0];
        w_curve.up    = w_up;
        w_curve.down  = w_down;
    end

    // global advance: the chain moves unless the output is held
    assign w_en            = !r_vld[NSTAGE-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_in_acc        = i_s_axis_tvalid && w_en;

    // valid and frame mark travel beside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTAGE-2:0], w_in_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_last <= {r_last[NSTAGE-2:0], i_s_axis_tlast};
        end
    end

    // per channel lane: remainder chain, branch stage, quotient chain
    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [7:0]         w_v;
        logic signed [10:0] w_x;

        assign w_v = i_s_axis_tdata[8*l +: 8];

        always_comb begin
            w_x            = $signed({3'b0, w_v}) + 11'sd256 - $signed({2'b0, r_start});
            w_a[l][0]      = '0;
            w_a[l][0].neg  = w_x[10];
            w_a[l][0].kind = spc_pkg::RES_DIV;
            w_a[l][0].rem  = spc_pkg::REM_W'(w_x[10] ? 11'(-w_x) : w_x);
            w_a[l][0].dvs  = w_aper;
        end

        for (genvar s = 0; s < NSTEP; s++) begin : g_rem
            spc_div_cell #(.SHIFT(NSTEP - 1 - s)) u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_lane (w_a[l][s]),
                .o_lane (w_a[l][s+1])
            );
        end

        spc_branch u_branch (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_curve (w_curve),
            .i_lane  (w_a[l][NSTEP]),
            .o_lane  (w_b[l][0])
        );

        for (genvar s = 0; s < NSTEP; s++) begin : g_quot
            spc_div_cell #(.SHIFT(NSTEP - 1 - s)) u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_lane (w_b[l][s]),
                .o_lane (w_b[l][s+1])
            );
        end

        // output register for this channel byte
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_data[8*l +: 8] <= spc_pkg::lane_byte(w_b[l][NSTEP]);
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[NSTAGE-1];
    assign o_m_axis_tdata  = r_data;
    assign o_m_axis_tlast  = r_last[NSTAGE-1];

    // checks on the pipeline control
    `SPC_ASSERT(a_ready_follows_out, o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready), "input ready does not follow output stall")
    `SPC_ASSERT_NEXT(a_accept_enters, i_s_axis_tvalid && o_s_axis_tready, r_vld[0], "accepted pixel missing from first stage")
    `SPC_ASSERT_NEXT(a_stall_freezes, !w_en, $stable(r_vld), "pipeline moved while stalled")

endmodule
